/* hw/rtl/rcalc_pkg.sv */
// Shared constants, types and character helpers for the radix integer calculator.
package rcalc_pkg;

   // Default sizes
   localparam int WORD_BITS_DEF  = 32;
   localparam int MAX_DIGITS_DEF = 32;
   localparam int DIGIT_BITS     = 5;

   // Field selectors on req_func
   localparam logic [1:0] FUNC_OP   = 2'd0;
   localparam logic [1:0] FUNC_A    = 2'd1;
   localparam logic [1:0] FUNC_B    = 2'd2;
   localparam logic [1:0] FUNC_TYPE = 2'd3;

   // Operator codes
   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_ADD  = 2'd1;
   localparam logic [1:0] OP_SUB  = 2'd2;
   localparam logic [1:0] OP_MUL  = 2'd3;

   // Error codes
   localparam logic [2:0] ERR_NONE  = 3'd0;
   localparam logic [2:0] ERR_TYPE  = 3'd1;
   localparam logic [2:0] ERR_OP    = 3'd2;
   localparam logic [2:0] ERR_BASE  = 3'd3;
   localparam logic [2:0] ERR_DIGIT = 3'd4;

   // Characters
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_O     = 8'h6F;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam logic [4:0] DIGIT_BAD = 5'd16;

   // Output word source
   typedef enum logic [2:0] {
      OUT_NONE,
      OUT_SIGN,
      OUT_LETTER,
      OUT_DIGIT,
      OUT_ERR
   } rcalc_out_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic              accept;
      logic              eval;
      logic              mul_step;
      logic              mag;
      logic              div_step;
      logic              dig_wr;
      logic              rd;
      logic              clear;
      rcalc_out_sel_type out_sel;
   } rcalc_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [2:0] error_code;
      logic       is_mul;
      logic       bit_last;
      logic       q_zero;
      logic       cnt_last;
      logic       cnt_zero;
      logic       neg;
   } rcalc_status_type;

   function automatic logic [4:0] letter_base(input logic [7:0] c);
      unique case (c)
         CH_B:    return 5'd2;
         CH_O:    return 5'd8;
         CH_D:    return 5'd10;
         CH_X:    return 5'd16;
         default: return 5'd0;
      endcase
   endfunction

   function automatic logic [7:0] base_letter(input logic [4:0] b);
      unique case (b)
         5'd2:    return CH_B;
         5'd8:    return CH_O;
         5'd10:   return CH_D;
         default: return CH_X;
      endcase
   endfunction

   function automatic logic [4:0] digit_value(input logic [7:0] c);
      logic [7:0] t;
      t = 8'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         t = c - CH_ZERO;
      end else if (c >= CH_LA && c <= CH_LF) begin
         t = c - CH_LA + 8'd10;
      end else if (c >= CH_UA && c <= CH_UF) begin
         t = c - CH_UA + 8'd10;
      end else begin
         t = {3'd0, DIGIT_BAD};
      end
      return t[4:0];
   endfunction

   function automatic logic [7:0] digit_char(input logic [4:0] d);
      if (d < 5'd10) begin
         return CH_ZERO + {3'd0, d};
      end
      return CH_UA + {3'd0, d} - 8'd10;
   endfunction

endpackage

/* hw/rtl/radix_integer_calculator_unit.sv */
// Multi-radix integer calculator: takes operator, operand and output-type
// characters one word per cycle and emits the result as characters. The word
// that ends the output-type field starts the calculation, and no input word is
// taken until its last result word is delivered: a multiply runs a shift-add
// unit, each result digit comes from the bit-serial radix divider, and each
// digit word is read from the digit RAM before it is offered. An error gives a
// single word with character 0, the error code and last set.
module radix_integer_calculator_unit #(
   parameter int WORD_BITS  = rcalc_pkg::WORD_BITS_DEF,
   parameter int MAX_DIGITS = rcalc_pkg::MAX_DIGITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic [1:0] req_func,
   input  logic       req_end_of_field,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic [2:0] rsp_error_code,
   output logic       rsp_last
);
   import rcalc_pkg::*;

   rcalc_cmd_type    cmd;
   rcalc_status_type status;

   rcalc_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_end_of_field(req_end_of_field),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .status          (status),
      .cmd             (cmd)
   );

   rcalc_datapath #(
      .WORD_BITS (WORD_BITS),
      .MAX_DIGITS(MAX_DIGITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .req_func        (req_func),
      .req_end_of_field(req_end_of_field),
      .cmd             (cmd),
      .status          (status),
      .out_char        (rsp_out_char),
      .error_code      (rsp_error_code),
      .last            (rsp_last)
   );

   // Input is closed while a result word is pending
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("input open while result pending");

   // An error word is always the last word
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code != ERR_NONE) |-> rsp_last)
      else $error("error word without last");

   // After the last word the block returns to taking input
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> (req_ready && !rsp_valid))
      else $error("block not idle after last word");

endmodule

/* hw/rtl/rcalc_ram.sv */
// Generic single-port-write, registered-read RAM.
module rcalc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/rcalc_datapath.sv */
// Datapath: field parsing, operand accumulation, shift-add multiplier, radix divider, output word.
module rcalc_datapath #(
   parameter int WORD_BITS  = rcalc_pkg::WORD_BITS_DEF,
   parameter int MAX_DIGITS = rcalc_pkg::MAX_DIGITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [7:0]                 req_ch,
   input  logic [1:0]                 req_func,
   input  logic                       req_end_of_field,
   input  rcalc_pkg::rcalc_cmd_type   cmd,
   output rcalc_pkg::rcalc_status_type status,
   output logic [7:0]                 out_char,
   output logic [2:0]                 error_code,
   output logic                       last
);
   import rcalc_pkg::*;

   localparam int BW = $clog2(WORD_BITS);
   localparam int CW = $clog2(MAX_DIGITS + 1);
   localparam int AW = $clog2(MAX_DIGITS);

   // Parse state
   logic [1:0]           op_ff, op_in;
   logic [5:0]           pos_ff, pos_in;
   logic [4:0]           base_ff, base_in;
   logic                 neg_ff, neg_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [WORD_BITS-1:0] first_ff, first_in;
   logic [3:0]           flags_ff, flags_in;

   // Compute state
   logic [WORD_BITS-1:0] prod_ff, mcand_ff, mplier_ff, q_ff;
   logic [4:0]           rem_ff;
   logic [BW-1:0]        bcnt_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 rneg_ff;
   logic [7:0]           out_char_ff;
   logic [2:0]           err_ff;
   logic                 last_ff;

   logic [WORD_BITS-1:0] scaled;
   logic [4:0]           dval;
   logic [2:0]           err_now;
   logic [5:0]           div_t, div_diff;
   logic                 div_ge;
   logic [CW-1:0]        cnt_dec;
   logic [DIGIT_BITS-1:0] rd_data;

   // Scale accumulator by the operand base
   always_comb begin
      unique case (base_ff)
         5'd2:    scaled = acc_ff << 1;
         5'd8:    scaled = acc_ff << 3;
         5'd10:   scaled = (acc_ff << 3) + (acc_ff << 1);
         default: scaled = acc_ff << 4;
      endcase
   end

   assign dval = digit_value(req_ch);

   // Next parse state for an accepted character
   always_comb begin
      op_in    = op_ff;
      base_in  = base_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      first_in = first_ff;
      flags_in = flags_ff;
      pos_in   = pos_ff;
      if (cmd.accept) begin
         unique case (req_func)
            FUNC_OP: begin
               if (pos_ff == 6'd0) begin
                  op_in = (req_ch == CH_PLUS)  ? OP_ADD :
                          (req_ch == CH_MINUS) ? OP_SUB :
                          (req_ch == CH_STAR)  ? OP_MUL : OP_NONE;
               end
            end
            FUNC_A, FUNC_B: begin
               if (pos_ff == 6'd0) begin
                  base_in = 5'd0;
                  neg_in  = 1'b0;
                  acc_in  = '0;
               end
               if (pos_ff == 6'd0 && req_ch == CH_MINUS) begin
                  neg_in = 1'b1;
               end else if (pos_ff == 6'd0 || (pos_ff == 6'd1 && neg_in)) begin
                  base_in = letter_base(req_ch);
                  if (base_in == 5'd0) begin
                     flags_in[{req_func[1], 1'b0}] = 1'b1;
                  end
               end else if (base_ff != 5'd0) begin
                  if (dval >= base_ff) begin
                     flags_in[{req_func[1], 1'b1}] = 1'b1;
                  end else begin
                     acc_in = scaled + {{(WORD_BITS-5){1'b0}}, dval};
                  end
               end
               if (req_end_of_field) begin
                  if (base_in == 5'd0) begin
                     flags_in[{req_func[1], 1'b0}] = 1'b1;
                  end
                  if (neg_in) begin
                     acc_in = '0 - acc_in;
                  end
                  if (req_func == FUNC_A) begin
                     first_in = acc_in;
                  end
               end
            end
            FUNC_TYPE: begin
               if (pos_ff == 6'd0) begin
                  base_in = letter_base(req_ch);
               end
            end
            default: begin
            end
         endcase
         pos_in = req_end_of_field ? 6'd0 : (pos_ff == 6'd63 ? 6'd63 : pos_ff + 6'd1);
      end
      if (cmd.clear) begin
         op_in    = OP_NONE;
         base_in  = 5'd0;
         neg_in   = 1'b0;
         acc_in   = '0;
         first_in = '0;
         flags_in = 4'd0;
      end
   end

   // Hold parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff    <= OP_NONE;
         pos_ff   <= 6'd0;
         base_ff  <= 5'd0;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
         first_ff <= '0;
         flags_ff <= 4'd0;
      end else begin
         op_ff    <= op_in;
         pos_ff   <= pos_in;
         base_ff  <= base_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
         first_ff <= first_in;
         flags_ff <= flags_in;
      end
   end

   // Error priority
   always_comb begin
      priority if (base_ff == 5'd0) err_now = ERR_TYPE;
      else if (op_ff == OP_NONE)    err_now = ERR_OP;
      else if (flags_ff[0])         err_now = ERR_BASE;
      else if (flags_ff[1])         err_now = ERR_DIGIT;
      else if (flags_ff[2])         err_now = ERR_BASE;
      else if (flags_ff[3])         err_now = ERR_DIGIT;
      else                          err_now = ERR_NONE;
   end

   // One restoring division step by the base
   assign div_t    = {rem_ff, q_ff[WORD_BITS-1]};
   assign div_ge   = div_t >= {1'b0, base_ff};
   assign div_diff = div_t - {1'b0, base_ff};
   assign cnt_dec  = cnt_ff - CW'(1);

   // Advance multiplier, divider and bit counter
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         prod_ff   <= (op_ff == OP_ADD) ? first_ff + acc_ff :
                      (op_ff == OP_SUB) ? first_ff - acc_ff : '0;
         mcand_ff  <= first_ff;
         mplier_ff <= acc_ff;
         bcnt_ff   <= '0;
      end
      if (cmd.mul_step) begin
         if (mplier_ff[0]) begin
            prod_ff <= prod_ff + mcand_ff;
         end
         mcand_ff  <= mcand_ff << 1;
         mplier_ff <= mplier_ff >> 1;
         bcnt_ff   <= bcnt_ff + BW'(1);
      end
      if (cmd.mag) begin
         rneg_ff <= prod_ff[WORD_BITS-1];
         q_ff    <= prod_ff[WORD_BITS-1] ? '0 - prod_ff : prod_ff;
         rem_ff  <= 5'd0;
         bcnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff  <= div_ge ? div_diff[4:0] : div_t[4:0];
         q_ff    <= {q_ff[WORD_BITS-2:0], div_ge};
         bcnt_ff <= bcnt_ff + BW'(1);
      end
      if (cmd.dig_wr) begin
         rem_ff  <= 5'd0;
         bcnt_ff <= '0;
      end
   end

   // Digit count
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.mag) begin
         cnt_ff <= '0;
      end else if (cmd.dig_wr) begin
         cnt_ff <= cnt_ff + CW'(1);
      end else if (cmd.rd) begin
         cnt_ff <= cnt_dec;
      end
   end

   rcalc_ram #(
      .WIDTH(DIGIT_BITS),
      .DEPTH(MAX_DIGITS)
   ) u_digits (
      .clock  (clock),
      .wr_en  (cmd.dig_wr),
      .wr_addr(cnt_ff[AW-1:0]),
      .wr_data(rem_ff),
      .rd_en  (cmd.rd),
      .rd_addr(cnt_dec[AW-1:0]),
      .rd_data(rd_data)
   );

   // Load the output word
   always_ff @(posedge clock) begin
      unique case (cmd.out_sel)
         OUT_SIGN: begin
            out_char_ff <= CH_MINUS;
            err_ff      <= ERR_NONE;
            last_ff     <= 1'b0;
         end
         OUT_LETTER: begin
            out_char_ff <= base_letter(base_ff);
            err_ff      <= ERR_NONE;
            last_ff     <= 1'b0;
         end
         OUT_DIGIT: begin
            out_char_ff <= digit_char(rd_data);
            err_ff      <= ERR_NONE;
            last_ff     <= (cnt_ff == '0);
         end
         OUT_ERR: begin
            out_char_ff <= CH_NUL;
            err_ff      <= err_now;
            last_ff     <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign out_char   = out_char_ff;
   assign error_code = err_ff;
   assign last       = last_ff;

   assign status.error_code = err_now;
   assign status.is_mul     = (op_ff == OP_MUL);
   assign status.bit_last   = (bcnt_ff == BW'(WORD_BITS - 1));
   assign status.q_zero     = (q_ff == '0);
   assign status.cnt_last   = (cnt_ff == CW'(MAX_DIGITS - 1));
   assign status.cnt_zero   = (cnt_ff == '0);
   assign status.neg        = rneg_ff;

endmodule

/* hw/rtl/rcalc_ctrl.sv */
// Controller: sequences parsing, evaluation, digit conversion and result emission.
module rcalc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_func,
   input  logic                        req_end_of_field,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  rcalc_pkg::rcalc_status_type status,
   output rcalc_pkg::rcalc_cmd_type    cmd
);
   import rcalc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EVAL,
      S_MUL,
      S_MAG,
      S_DIV,
      S_WR,
      S_SIGN,
      S_LETTER,
      S_RD,
      S_DIG,
      S_ERR
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = valid_ff;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      cmd.accept   = 1'b0;
      cmd.eval     = 1'b0;
      cmd.mul_step = 1'b0;
      cmd.mag      = 1'b0;
      cmd.div_step = 1'b0;
      cmd.dig_wr   = 1'b0;
      cmd.rd       = 1'b0;
      cmd.clear    = 1'b0;
      cmd.out_sel  = OUT_NONE;
      unique case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && req_func == FUNC_TYPE && req_end_of_field) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (status.error_code != ERR_NONE) begin
               state_in = S_ERR;
            end else begin
               cmd.eval = 1'b1;
               state_in = status.is_mul ? S_MUL : S_MAG;
            end
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            if (status.bit_last) begin
               state_in = S_MAG;
            end
         end
         S_MAG: begin
            cmd.mag  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.bit_last) begin
               state_in = S_WR;
            end
         end
         S_WR: begin
            cmd.dig_wr = 1'b1;
            if (!status.q_zero && !status.cnt_last) begin
               state_in = S_DIV;
            end else begin
               state_in = status.neg ? S_SIGN : S_LETTER;
            end
         end
         S_SIGN: begin
            if (!valid_ff) begin
               cmd.out_sel = OUT_SIGN;
               valid_in    = 1'b1;
            end else if (rsp_ready) begin
               valid_in = 1'b0;
               state_in = S_LETTER;
            end
         end
         S_LETTER: begin
            if (!valid_ff) begin
               cmd.out_sel = OUT_LETTER;
               valid_in    = 1'b1;
            end else if (rsp_ready) begin
               valid_in = 1'b0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_DIG;
         end
         S_DIG: begin
            if (!valid_ff) begin
               cmd.out_sel = OUT_DIGIT;
               valid_in    = 1'b1;
            end else if (rsp_ready) begin
               valid_in = 1'b0;
               if (status.cnt_zero) begin
                  cmd.clear = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_ERR: begin
            if (!valid_ff) begin
               cmd.out_sel = OUT_ERR;
               valid_in    = 1'b1;
            end else if (rsp_ready) begin
               valid_in  = 1'b0;
               cmd.clear = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

/* bench/radix_integer_calculator_unit_tb.sv */
// Self-checking testbench for the radix integer calculator unit.
`timescale 1ns / 1ps

module radix_integer_calculator_unit_tb;
   import rcalc_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_WORDS = 245;

   typedef struct packed {
      logic [7:0] ch;
      logic [1:0] func;
      logic       eof;
      logic [2:0] fixed_err;  // ERR_NONE: predicted, else a single error word
   } stim_word_type;

   typedef struct packed {
      logic [7:0] ch;
      logic [2:0] err;
      logic       last;
   } calc_char_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_ch;
   logic [1:0] req_func;
   logic       req_end_of_field;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_char;
   logic [2:0] rsp_error_code;
   logic       rsp_last;

   // Calculator shadow state
   logic [1:0]  calc_op;
   logic [5:0]  calc_pos;
   logic [4:0]  calc_base;
   logic        calc_neg;
   logic [31:0] calc_acc;
   logic [31:0] calc_first;
   logic [3:0]  calc_errs;

   calc_char_type expected_chars[$];
   int            mismatches;
   int            words_sent;
   int            chars_seen;
   int            calcs_done;
   int            error_calcs;
   int            cycles;
   int            send_idle;
   int            recv_idle;

   stim_word_type directed_table[25] = '{
      '{"q", FUNC_TYPE, 1'b1, ERR_TYPE},
      '{CH_D, FUNC_TYPE, 1'b1, ERR_OP},
      '{CH_PLUS, FUNC_OP, 1'b1, ERR_NONE},
      '{"z", FUNC_A, 1'b1, ERR_NONE},
      '{CH_D, FUNC_TYPE, 1'b1, ERR_BASE},
      '{CH_MINUS, FUNC_OP, 1'b1, ERR_NONE},
      '{CH_O, FUNC_A, 1'b0, ERR_NONE},
      '{"9", FUNC_A, 1'b1, ERR_NONE},
      '{CH_X, FUNC_TYPE, 1'b1, ERR_DIGIT},
      '{CH_STAR, FUNC_OP, 1'b1, ERR_NONE},
      '{CH_MINUS, FUNC_A, 1'b0, ERR_NONE},
      '{CH_X, FUNC_A, 1'b0, ERR_NONE},
      '{"8", FUNC_A, 1'b0, ERR_NONE},
      '{"0", FUNC_A, 1'b0, ERR_NONE},
      '{"0", FUNC_A, 1'b0, ERR_NONE},
      '{"0", FUNC_A, 1'b0, ERR_NONE},
      '{"0", FUNC_A, 1'b0, ERR_NONE},
      '{"0", FUNC_A, 1'b0, ERR_NONE},
      '{"0", FUNC_A, 1'b0, ERR_NONE},
      '{"0", FUNC_A, 1'b1, ERR_NONE},
      '{CH_D, FUNC_B, 1'b0, ERR_NONE},
      '{"1", FUNC_B, 1'b1, ERR_NONE},
      '{CH_B, FUNC_TYPE, 1'b1, ERR_NONE},
      '{CH_MINUS, FUNC_OP, 1'b1, ERR_NONE},
      '{CH_O, FUNC_TYPE, 1'b1, ERR_NONE}
   };

   radix_integer_calculator_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_ch           (req_ch),
      .req_func         (req_func),
      .req_end_of_field (req_end_of_field),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_char     (rsp_out_char),
      .rsp_error_code   (rsp_error_code),
      .rsp_last         (rsp_last)
   );

   // Generate the clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic logic [4:0] radix_of(input logic [7:0] c);
      case (c)
         CH_B:    return 5'd2;
         CH_O:    return 5'd8;
         CH_D:    return 5'd10;
         CH_X:    return 5'd16;
         default: return 5'd0;
      endcase
   endfunction

   function automatic logic [4:0] digit_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return 5'(c - "0");
      if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
      if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
      return DIGIT_BAD;
   endfunction

   // Emit the characters of a finished calculation
   task automatic emit_calc(ref calc_char_type res[$]);
      logic [2:0]  err;
      logic [31:0] v;
      logic [31:0] mag;
      logic [4:0]  digs[$];
      logic [7:0]  letter;
      logic [4:0]  d;
      err = ERR_NONE;
      if (calc_base == 0) err = ERR_TYPE;
      else if (calc_op == OP_NONE) err = ERR_OP;
      else if (calc_errs[0]) err = ERR_BASE;
      else if (calc_errs[1]) err = ERR_DIGIT;
      else if (calc_errs[2]) err = ERR_BASE;
      else if (calc_errs[3]) err = ERR_DIGIT;
      if (err != ERR_NONE) begin
         res.push_back('{8'h00, err, 1'b1});
         return;
      end
      case (calc_op)
         OP_ADD:  v = calc_first + calc_acc;
         OP_SUB:  v = calc_first - calc_acc;
         default: v = calc_first * calc_acc;
      endcase
      mag = v[31] ? -v : v;
      do begin
         digs.push_front(5'(mag % calc_base));
         mag = mag / calc_base;
      end while (mag != 0 && digs.size() < 32);
      case (calc_base)
         5'd2:    letter = CH_B;
         5'd8:    letter = CH_O;
         5'd10:   letter = CH_D;
         default: letter = CH_X;
      endcase
      if (v[31]) res.push_back('{CH_MINUS, ERR_NONE, 1'b0});
      res.push_back('{letter, ERR_NONE, 1'b0});
      while (digs.size() > 0) begin
         d = digs.pop_front();
         res.push_back('{(d < 10) ? 8'("0" + d) : 8'("A" + d - 10), ERR_NONE,
                         digs.size() == 0});
      end
   endtask

   // Advance the shadow state by one accepted word
   task automatic predict_word(input logic [7:0] c, input logic [1:0] f, input logic eof,
                               ref calc_char_type res[$]);
      logic [5:0] p;
      logic [4:0] d;
      int         sh;
      p = calc_pos;
      if (f == FUNC_OP) begin
         if (p == 0)
            calc_op = (c == CH_PLUS) ? OP_ADD : (c == CH_MINUS) ? OP_SUB :
                      (c == CH_STAR) ? OP_MUL : OP_NONE;
      end else if (f == FUNC_A || f == FUNC_B) begin
         sh = (f == FUNC_B) ? 2 : 0;
         if (p == 0) begin
            calc_base = 0;
            calc_neg  = 1'b0;
            calc_acc  = 0;
         end
         if (p == 0 && c == CH_MINUS) begin
            calc_neg = 1'b1;
         end else if (p == 0 || (p == 1 && calc_neg)) begin
            calc_base = radix_of(c);
            if (calc_base == 0) calc_errs[sh] = 1'b1;
         end else if (calc_base != 0) begin
            d = digit_of(c);
            if (d >= calc_base) calc_errs[sh+1] = 1'b1;
            else calc_acc = calc_acc * calc_base + d;
         end
         if (eof) begin
            if (calc_base == 0) calc_errs[sh] = 1'b1;
            if (calc_neg) calc_acc = -calc_acc;
            if (f == FUNC_A) calc_first = calc_acc;
         end
      end else begin
         if (p == 0) calc_base = radix_of(c);
         if (eof) begin
            emit_calc(res);
            calc_op    = OP_NONE;
            calc_base  = 0;
            calc_neg   = 1'b0;
            calc_acc   = 0;
            calc_first = 0;
            calc_errs  = 0;
         end
      end
      calc_pos = eof ? 6'd0 : (p < 63 ? p + 6'd1 : 6'd63);
   endtask

   // Drive one word and hold it until taken, then book its expected characters
   task automatic send_word(input stim_word_type w);
      calc_char_type res[$];
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid        <= 1'b1;
      req_ch           <= w.ch;
      req_func         <= w.func;
      req_end_of_field <= w.eof;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      predict_word(w.ch, w.func, w.eof, res);
      if (w.fixed_err != ERR_NONE) begin
         res = {};
         res.push_back('{8'h00, w.fixed_err, 1'b1});
      end
      foreach (res[i]) expected_chars.push_back(res[i]);
   endtask

   task automatic send_char(input logic [7:0] c, input logic [1:0] f, input logic eof);
      send_word('{c, f, eof, ERR_NONE});
   endtask

   // Pick a character: mostly valid digits of the base, sometimes garbage
   function automatic logic [7:0] pick_digit(input logic [4:0] b);
      int d;
      if (b == 0 || $urandom_range(99) < 5) return 8'($urandom_range(255));
      d = $urandom_range(b - 1);
      if (d < 10) return 8'("0" + d);
      return $urandom_range(1) ? 8'("A" + d - 10) : 8'("a" + d - 10);
   endfunction

   function automatic logic [7:0] pick_letter();
      case ($urandom_range(9))
         0, 1:    return CH_B;
         2, 3:    return CH_O;
         4, 5:    return CH_D;
         6, 7:    return CH_X;
         8:       return CH_MINUS;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Send one operand field: optional sign, base letter, digits
   task automatic send_operand(input logic [1:0] f);
      logic [7:0] letter;
      int         n;
      if ($urandom_range(3) == 0) send_char(CH_MINUS, f, 1'b0);
      letter = pick_letter();
      n = ($urandom_range(19) == 0) ? $urandom_range(33, 70) : $urandom_range(0, 11);
      send_char(letter, f, n == 0);
      for (int i = 0; i < n; i++) send_char(pick_digit(radix_of(letter)), f, i == n - 1);
   endtask

   // Send one random calculation, well formed or noise
   task automatic send_calc();
      logic [7:0] opc;
      int         n;
      if ($urandom_range(99) < 15) begin
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++)
            send_char(8'($urandom_range(255)), 2'($urandom_range(3)), 1'($urandom_range(1)));
         return;
      end
      case ($urandom_range(9))
         0, 1, 2: opc = CH_PLUS;
         3, 4, 5: opc = CH_MINUS;
         6, 7, 8: opc = CH_STAR;
         default: opc = 8'($urandom_range(255));
      endcase
      if ($urandom_range(19) != 0) begin
         send_char(opc, FUNC_OP, $urandom_range(3) != 0);
         if (!req_end_of_field) send_char(8'($urandom_range(255)), FUNC_OP, 1'b1);
      end
      if ($urandom_range(19) != 0) send_operand(FUNC_A);
      if ($urandom_range(19) != 0) send_operand(FUNC_B);
      send_char(pick_letter(), FUNC_TYPE, $urandom_range(4) != 0);
      if (!req_end_of_field) send_char(8'($urandom_range(255)), FUNC_TYPE, 1'b1);
   endtask

   // Toggle receiver readiness
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // Compare each delivered word with the oldest expectation
   always @(posedge clock) begin
      calc_char_type exp_c;
      if (!reset && rsp_valid && rsp_ready) begin
         chars_seen++;
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected word char=%h err=%0d last=%0b", $realtime,
                     rsp_out_char, rsp_error_code, rsp_last);
            mismatches++;
         end else begin
            exp_c = expected_chars.pop_front();
            if (exp_c.last) calcs_done++;
            if (exp_c.last && exp_c.err != ERR_NONE) error_calcs++;
            if (rsp_out_char !== exp_c.ch) begin
               $display("%0t: out_char expected %h actual %h", $realtime, exp_c.ch,
                        rsp_out_char);
               mismatches++;
            end
            if (rsp_error_code !== exp_c.err) begin
               $display("%0t: error_code expected %0d actual %0d", $realtime, exp_c.err,
                        rsp_error_code);
               mismatches++;
            end
            if (rsp_last !== exp_c.last) begin
               $display("%0t: last expected %0b actual %0b", $realtime, exp_c.last,
                        rsp_last);
               mismatches++;
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int wait_cycles;
      mismatches       = 0;
      words_sent       = 0;
      chars_seen       = 0;
      calcs_done       = 0;
      error_calcs      = 0;
      cycles           = 0;
      send_idle        = 12;
      recv_idle        = 87;
      calc_op          = OP_NONE;
      calc_pos         = 0;
      calc_base        = 0;
      calc_neg         = 1'b0;
      calc_acc         = 0;
      calc_first       = 0;
      calc_errs        = 0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_ch           = 8'h00;
      req_func         = FUNC_OP;
      req_end_of_field = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      foreach (directed_table[i]) send_word(directed_table[i]);

      // Random calculations in three idling phases
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 12 : (ph == 1) ? 87 : 0;
         recv_idle = (ph == 0) ? 87 : (ph == 1) ? 12 : 0;
         while (words_sent < 25 + (ph + 1) * RANDOM_WORDS / 3) send_calc();
      end
      req_valid <= 1'b0;

      // Drain remaining characters
      while (expected_chars.size() != 0) @(posedge clock);
      wait_cycles = 0;
      while (wait_cycles < 200) begin
         @(posedge clock);
         wait_cycles++;
      end

      $display("Sent %0d words over %0d calculations (%0d ending in an error code);",
               words_sent, calcs_done, error_calcs);
      $display("checked %0d result characters under three idling patterns.", chars_seen);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
